// ===== hdl/rtd_pkg.sv =====
// rtd_pkg: widths, constants and stage-to-stage types of the rtd code to temperature pipeline
// no dependencies; imported by every module under hdl
package rtd_pkg;

  localparam int CodeW    = 15;
  localparam int NomW     = 11;
  localparam int RefW     = 13;
  localparam int CfgW     = 13;
  localparam int TempW    = 19;
  localparam int FracBits = 16;

  // ratio divider: floor(code * ref * 2^FracBits / (2^CodeW * nom))
  localparam int RatioShift = FracBits - CodeW;
  localparam int NumW       = CodeW + RefW + RatioShift;
  localparam int RqW        = FracBits + 4;
  localparam int PolyRW     = FracBits + 1;
  localparam logic [NumW-1:0] RatioMax = NumW'(64'd8 << FracBits);

  // discriminant and square root
  localparam int RadW     = 62;
  localparam int RootW    = RadW / 2;
  localparam int SqStages = RadW / 2;
  localparam int DiscW    = 56;
  localparam int DiffW    = 32;
  localparam logic signed [DiscW-1:0] DiscBase = 56'sd152748088900 * 56'sd65536;
  localparam logic [RootW-1:0] ARoot = 31'd1600839680;

  // polynomial accumulator
  localparam int AccW = 25;

  // output range
  localparam int TempMax = 262143;
  localparam int TempMin = -65536;

  typedef struct packed {
    logic           vld;
    logic           ovf;
    logic [RqW-1:0] rq;
  } rtd_ratio_t;

  typedef struct packed {
    logic                    vld;
    logic                    bad;
    logic [PolyRW-1:0]       rq;
    logic signed [DiffW-1:0] diff;
  } rtd_root_t;

  typedef struct packed {
    logic                    vld;
    logic                    bad;
    logic signed [DiffW-1:0] diff;
    logic signed [AccW-1:0]  acc;
  } rtd_poly_t;

endpackage

// ===== hdl/rtd_code_to_temperature.sv =====
// rtd_code_to_temperature: rtd converter code to temperature in 1/256 celsius
// throughput: one code per cycle; busy_o stays low, the receiver cannot stall
// the pipeline length is set mostly by the bit-per-stage ratio divider and square root
// reset: async active low, clears pipeline valid bits; nominal 100 ohm, reference 430 ohm
// depends on rtd_pkg, rtd_ratio_div, rtd_isqrt, rtd_poly, rtd_scale
module rtd_code_to_temperature (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [rtd_pkg::CodeW-1:0]        rtd_code_i,
  output logic                             done_o,
  output logic signed [rtd_pkg::TempW-1:0] temperature_o,
  output logic                             used_polynomial_o,
  output logic                             saturated_o,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [rtd_pkg::CfgW-1:0]         cfg_data_i
);
  import rtd_pkg::*;

  localparam logic CfgNominal   = 1'b0;
  localparam logic CfgReference = 1'b1;

  logic [NomW-1:0] nom_q;
  logic [RefW-1:0] ref_q;
  logic [NomW-1:0] nom_eff;

  rtd_ratio_t ratio;
  rtd_root_t  root;
  rtd_poly_t  poly;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nom_q <= NomW'(100);
      ref_q <= RefW'(430);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgNominal:   nom_q <= cfg_data_i[NomW-1:0];
        CfgReference: ref_q <= cfg_data_i[RefW-1:0];
        default:      ;
      endcase
    end
  end

  // a zero nominal acts as one ohm
  assign nom_eff = (nom_q == '0) ? NomW'(1) : nom_q;
  assign busy_o  = 1'b0;

  rtd_ratio_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (start_i),
    .code_i  (rtd_code_i),
    .ref_i   (ref_q),
    .nom_i   (nom_eff),
    .ratio_o (ratio)
  );

  rtd_isqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ratio_i (ratio),
    .root_o  (root)
  );

  rtd_poly u_poly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .root_i (root),
    .poly_o (poly)
  );

  rtd_scale u_scale (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .poly_i            (poly),
    .done_o            (done_o),
    .temperature_o     (temperature_o),
    .used_polynomial_o (used_polynomial_o),
    .saturated_o       (saturated_o)
  );

endmodule

// ===== hdl/rtd_ratio_div.sv =====
// rtd_ratio_div: pipelined restoring divider, one quotient bit per stage, code * ref / nom
// depends on rtd_pkg
module rtd_ratio_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vld_i,
  input  logic [rtd_pkg::CodeW-1:0]  code_i,
  input  logic [rtd_pkg::RefW-1:0]   ref_i,
  input  logic [rtd_pkg::NomW-1:0]   nom_i,
  output rtd_pkg::rtd_ratio_t        ratio_o
);
  import rtd_pkg::*;

  logic [NumW-1:0] num_q [NumW+1];
  logic [NomW-1:0] rem_q [NumW+1];
  logic [NumW-1:0] quo_q [NumW+1];
  logic [NumW:0]   vld_q;

  logic [NomW:0]   trial [NumW];
  logic [NumW-1:0] ge;
  logic [NomW-1:0] rem_d [NumW];

  logic           out_vld_q;
  logic           ovf_q;
  logic [RqW-1:0] rq_q;

  always_comb begin
    for (int i = 0; i < NumW; i++) begin
      trial[i] = {rem_q[i], num_q[i][NumW-1]};
      ge[i]    = trial[i] >= {1'b0, nom_i};
      rem_d[i] = ge[i] ? NomW'(trial[i] - {1'b0, nom_i}) : NomW'(trial[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[NumW-1:0], vld_i};
      out_vld_q <= vld_q[NumW];
    end
  end

  always_ff @(posedge clk_i) begin
    num_q[0] <= (NumW'(code_i) * NumW'(ref_i)) << RatioShift;
    rem_q[0] <= '0;
    quo_q[0] <= '0;
    for (int i = 0; i < NumW; i++) begin
      num_q[i+1] <= num_q[i] << 1;
      rem_q[i+1] <= rem_d[i];
      quo_q[i+1] <= {quo_q[i][NumW-2:0], ge[i]};
    end
    rq_q  <= quo_q[NumW][RqW-1:0];
    ovf_q <= quo_q[NumW] > RatioMax;
  end

  assign ratio_o.vld = out_vld_q;
  assign ratio_o.ovf = ovf_q;
  assign ratio_o.rq  = rq_q;

endmodule

// ===== hdl/rtd_isqrt.sv =====
// rtd_isqrt: discriminant of the quadratic and its pipelined integer square root
// depends on rtd_pkg; one radicand bit pair per stage
module rtd_isqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rtd_pkg::rtd_ratio_t ratio_i,
  output rtd_pkg::rtd_root_t  root_o
);
  import rtd_pkg::*;

  localparam logic signed [9:0]  FourBE8 = 10'sd231;
  localparam logic signed [27:0] ScaleE8 = 28'sd100000000;

  logic signed [RqW:0]   dlt;
  logic signed [27:0]    m1_d;
  logic signed [27:0]    m1_q;
  logic signed [DiscW-1:0] m2_d;
  logic signed [DiscW-1:0] m2_q;
  logic signed [DiscW-1:0] k_d;
  logic                  ovf_a_q, ovf_b_q;
  logic [PolyRW-1:0]     rq_a_q, rq_b_q;
  logic [1:0]            pre_vld_q;

  logic [RadW-1:0]   rad_q  [SqStages+1];
  logic [RadW-1:0]   root_q [SqStages+1];
  logic              bad_q  [SqStages+1];
  logic [PolyRW-1:0] rq_q   [SqStages+1];
  logic [SqStages:0] vld_q;

  logic [RadW-1:0] bitv   [SqStages];
  logic [RadW-1:0] trial  [SqStages];
  logic [SqStages-1:0] ge;
  logic [RadW-1:0] rad_d  [SqStages];
  logic [RadW-1:0] root_d [SqStages];

  logic [RootW-1:0]        s;
  logic signed [DiffW-1:0] diff_q;
  logic                    bad_o_q;
  logic [PolyRW-1:0]       rq_o_q;
  logic                    vld_o_q;

  assign dlt  = $signed((RqW+1)'(64'd1 << FracBits)) - $signed({1'b0, ratio_i.rq});
  assign m1_d = dlt * FourBE8;
  assign m2_d = m1_q * ScaleE8;
  assign k_d  = DiscBase + m2_q;

  always_comb begin
    for (int j = 0; j < SqStages; j++) begin
      bitv[j]   = RadW'(1) << (2 * (SqStages - 1 - j));
      trial[j]  = root_q[j] + bitv[j];
      ge[j]     = rad_q[j] >= trial[j];
      rad_d[j]  = ge[j] ? rad_q[j] - trial[j] : rad_q[j];
      root_d[j] = ge[j] ? (root_q[j] >> 1) + bitv[j] : root_q[j] >> 1;
    end
  end

  assign s = root_q[SqStages][RootW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= '0;
      vld_q     <= '0;
      vld_o_q   <= 1'b0;
    end else begin
      pre_vld_q <= {pre_vld_q[0], ratio_i.vld};
      vld_q     <= {vld_q[SqStages-1:0], pre_vld_q[1]};
      vld_o_q   <= vld_q[SqStages];
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q    <= m1_d;
    ovf_a_q <= ratio_i.ovf;
    rq_a_q  <= ratio_i.rq[PolyRW-1:0];
    m2_q    <= m2_d;
    ovf_b_q <= ovf_a_q;
    rq_b_q  <= rq_a_q;
    rad_q[0]  <= {k_d[RadW-9:0], 8'b0};
    root_q[0] <= '0;
    bad_q[0]  <= ovf_b_q | k_d[DiscW-1];
    rq_q[0]   <= rq_b_q;
    for (int j = 0; j < SqStages; j++) begin
      rad_q[j+1]  <= rad_d[j];
      root_q[j+1] <= root_d[j];
      bad_q[j+1]  <= bad_q[j];
      rq_q[j+1]   <= rq_q[j];
    end
    diff_q  <= $signed({1'b0, ARoot}) - $signed({1'b0, s});
    bad_o_q <= bad_q[SqStages];
    rq_o_q  <= rq_q[SqStages];
  end

  assign root_o.vld  = vld_o_q;
  assign root_o.bad  = bad_o_q;
  assign root_o.rq   = rq_o_q;
  assign root_o.diff = diff_q;

endmodule

// ===== hdl/rtd_poly.sv =====
// rtd_poly: fifth-order below-zero polynomial, one horner step per multiply and add stage pair
// depends on rtd_pkg
module rtd_poly (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rtd_pkg::rtd_root_t root_i,
  output rtd_pkg::rtd_poly_t poly_o
);
  import rtd_pkg::*;

  localparam int ProdW = AccW + PolyRW;
  localparam int Steps = 5;

  function automatic logic signed [AccW-1:0] coef(input int k);
    logic signed [AccW-1:0] c;
    case (k)
      0:       c = AccW'(-32'sd2420200);
      1:       c = AccW'(32'sd2222800);
      2:       c = AccW'(32'sd258590);
      3:       c = AccW'(-32'sd48260);
      4:       c = AccW'(-32'sd28183);
      default: c = AccW'(32'sd15243);
    endcase
    return c;
  endfunction

  // round half away from zero, drop FracBits bits
  function automatic logic signed [AccW-1:0] rnd(input logic signed [ProdW-1:0] p);
    logic [ProdW-1:0] mag;
    logic [ProdW-1:0] q;
    mag = p[ProdW-1] ? ProdW'(-p) : ProdW'(p);
    q   = (mag + ProdW'(64'd1 << (FracBits - 1))) >> FracBits;
    return p[ProdW-1] ? AccW'(-q) : AccW'(q);
  endfunction

  logic signed [AccW-1:0]  acc_q    [Steps+1];
  logic                    bad_a_q  [Steps+1];
  logic [PolyRW-1:0]       rq_a_q   [Steps+1];
  logic signed [DiffW-1:0] diff_a_q [Steps+1];
  logic [Steps:0]          va_q;

  logic signed [ProdW-1:0] prod_q   [Steps];
  logic                    bad_m_q  [Steps];
  logic [PolyRW-1:0]       rq_m_q   [Steps];
  logic signed [DiffW-1:0] diff_m_q [Steps];
  logic [Steps-1:0]        vm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= '0;
      vm_q <= '0;
    end else begin
      va_q[0] <= root_i.vld;
      for (int j = 0; j < Steps; j++) begin
        vm_q[j]   <= va_q[j];
        va_q[j+1] <= vm_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q[0]    <= coef(Steps);
    bad_a_q[0]  <= root_i.bad;
    rq_a_q[0]   <= root_i.rq;
    diff_a_q[0] <= root_i.diff;
    for (int j = 0; j < Steps; j++) begin
      prod_q[j]     <= acc_q[j] * $signed({1'b0, rq_a_q[j]});
      bad_m_q[j]    <= bad_a_q[j];
      rq_m_q[j]     <= rq_a_q[j];
      diff_m_q[j]   <= diff_a_q[j];
      acc_q[j+1]    <= rnd(prod_q[j]) + coef(Steps - 1 - j);
      bad_a_q[j+1]  <= bad_m_q[j];
      rq_a_q[j+1]   <= rq_m_q[j];
      diff_a_q[j+1] <= diff_m_q[j];
    end
  end

  assign poly_o.vld  = va_q[Steps];
  assign poly_o.bad  = bad_a_q[Steps];
  assign poly_o.diff = diff_a_q[Steps];
  assign poly_o.acc  = acc_q[Steps];

endmodule

// ===== hdl/rtd_scale.sv =====
// rtd_scale: branch select, rounding division by a constant via reciprocal, saturation
// depends on rtd_pkg; drives the result ports
module rtd_scale (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rtd_pkg::rtd_poly_t         poly_i,
  output logic                       done_o,
  output logic signed [rtd_pkg::TempW-1:0] temperature_o,
  output logic                       used_polynomial_o,
  output logic                       saturated_o
);
  import rtd_pkg::*;

  localparam int NW    = 31;
  localparam int RcpW  = 23;
  localparam int DivW  = 11;
  localparam int QW    = 22;
  localparam int PolyShift = 4;
  localparam logic [NW-1:0]   QuadRnd   = 31'd924;
  localparam logic [NW-1:0]   PolyRnd   = 31'd312;
  localparam logic [DivW-1:0] QuadDiv   = 11'd1848;
  localparam logic [DivW-1:0] PolyDiv   = 11'd625;
  localparam logic [RcpW-1:0] QuadRecip = RcpW'((64'd1 << 32) / 64'd1848);
  localparam logic [RcpW-1:0] PolyRecip = RcpW'((64'd1 << 32) / 64'd625);
  localparam logic signed [QW:0] TopLim = (QW+1)'(TempMax);
  localparam logic signed [QW:0] BotLim = (QW+1)'(TempMin);

  logic                sel;
  logic [AccW-1:0]     mag;
  logic [NW-1:0]       n_d;
  logic [NW+RcpW-1:0]  prod;
  logic [NW+1:0]       chk;
  logic [NW+1:0]       rem;
  logic signed [QW:0]  t;

  logic [NW-1:0] n1_q, n2_q;
  logic          sel1_q, sel2_q, sel3_q;
  logic          neg1_q, neg2_q, neg3_q;
  logic          bad1_q, bad2_q, bad3_q;
  logic [QW-1:0] q0_q, q3_q;
  logic [3:0]    vld_q;

  logic signed [TempW-1:0] temp_q;
  logic                    poly_q;
  logic                    sat_q;

  assign sel  = poly_i.diff[DiffW-1];
  assign mag  = poly_i.acc[AccW-1] ? AccW'(-poly_i.acc) : AccW'(poly_i.acc);
  assign n_d  = sel ? NW'({mag, {PolyShift{1'b0}}}) + PolyRnd
                    : NW'(poly_i.diff[NW-1:0]) + QuadRnd;
  assign prod = n1_q * (sel1_q ? PolyRecip : QuadRecip);
  assign chk  = q0_q * (sel2_q ? PolyDiv : QuadDiv);
  assign rem  = (NW+2)'(n2_q) - chk;
  assign t    = neg3_q ? -$signed({1'b0, q3_q}) : $signed({1'b0, q3_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], poly_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    n1_q   <= n_d;
    sel1_q <= sel;
    neg1_q <= sel & poly_i.acc[AccW-1];
    bad1_q <= poly_i.bad;

    q0_q   <= prod[32 +: QW];
    n2_q   <= n1_q;
    sel2_q <= sel1_q;
    neg2_q <= neg1_q;
    bad2_q <= bad1_q;

    q3_q   <= q0_q + QW'(rem >= (NW+2)'(sel2_q ? PolyDiv : QuadDiv));
    sel3_q <= sel2_q;
    neg3_q <= neg2_q;
    bad3_q <= bad2_q;

    if (bad3_q) begin
      temp_q <= TempW'(TempMax);
      poly_q <= 1'b1;
      sat_q  <= 1'b1;
    end else if (t > TopLim) begin
      temp_q <= TempW'(TempMax);
      poly_q <= sel3_q;
      sat_q  <= 1'b1;
    end else if (t < BotLim) begin
      temp_q <= TempW'(TempMin);
      poly_q <= sel3_q;
      sat_q  <= 1'b1;
    end else begin
      temp_q <= t[TempW-1:0];
      poly_q <= sel3_q;
      sat_q  <= 1'b0;
    end
  end

  assign done_o            = vld_q[3];
  assign temperature_o     = temp_q;
  assign used_polynomial_o = poly_q;
  assign saturated_o       = sat_q;

endmodule
